// ===== rtl/rfw_pkg.sv =====
// shared types and constants for the resample filter weight generator
package rfw_pkg;

  localparam int MAX_DECIMATION   = 8;
  localparam int WEIGHT_FRAC_BITS = 15;
  localparam int MAX_TAPS         = 18;
  localparam int PHASE_BITS       = 12;

  // quotient bits, raw weight bits, numerator and sum widths
  localparam int QUO_W = WEIGHT_FRAC_BITS + 1;
  localparam int RAW_W = 16;
  localparam int NUM_W = RAW_W + WEIGHT_FRAC_BITS + 1;
  localparam int SUM_W = 20;
  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam logic [11:0] DEC_MAX = 12'(MAX_DECIMATION * 256);

  typedef enum logic {
    KIND_BOX  = 1'b0,
    KIND_TENT = 1'b1
  } filter_kind_e;

  typedef struct packed {
    logic signed [12:0] phase;
    logic        [11:0] decimation;
  } rfw_req_t;

  typedef struct packed {
    logic signed [4:0] tap_offset;
    logic [15:0]       weight;
    logic              last_tap;
  } rfw_res_t;

endpackage

// ===== rtl/rfw_divider.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module rfw_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rfw_pkg::NUM_W-1:0] num_i,
  input  logic [rfw_pkg::SUM_W-1:0] den_i,
  output logic                      done_o,
  output logic [rfw_pkg::QUO_W-1:0] quo_o
);
  import rfw_pkg::*;

  logic [SUM_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] den_q;
  logic [QUO_W-1:0] sh_q, sh_d;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [SUM_W:0]   trial;
  logic             qbit;

  // shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem_q, sh_q[QUO_W-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? SUM_W'(trial - {1'b0, den_q}) : trial[SUM_W-1:0];
    sh_d  = {sh_q[QUO_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= SUM_W'(num_i[NUM_W-1:QUO_W]);
      sh_q  <= num_i[QUO_W-1:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign done_o = done_q;
  // empty sum gives zero weight
  assign quo_o  = (den_q == '0) ? '0 : sh_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !run_q)
    else $error("divider done while still running");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> run_q)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) run_q |-> rem_q < den_q)
    else $error("divider remainder out of range");

endmodule

// ===== rtl/resample_filter_weight_generator.sv =====
// top level: tap sequencer, sum pass and serial normalization
//
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------
// request   | start_i, busy_o            | req_i (phase, decimation)
// result    | res_valid_o (one cycle)    | res_o (tap_offset, weight, last)
// config    | cfg_we_i                   | cfg_wdata_i (filter_kind)
//
// a request is taken when start_i is high and busy_o is low
// after the accept, a sum pass over the taps forms the weight sum,
// then each tap gets a divider load, a serial division and a handoff;
// the serial divider sets the pace
// results are strobed for one cycle each and cannot be stalled
// reset leaves the block idle with the tent filter selected
module resample_filter_weight_generator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  rfw_pkg::rfw_req_t req_i,
  output logic              res_valid_o,
  output rfw_pkg::rfw_res_t res_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);
  import rfw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_WAIT
  } state_e;

  state_e             state_q;
  filter_kind_e       kind_q;
  logic signed [12:0] p_q;
  logic [15:0]        dq_q;
  logic               box_q;
  logic signed [4:0]  lo_q, hi_q, idx_q;
  logic [4:0]         cnt_q;
  logic [SUM_W-1:0]   sum_q;
  logic               res_valid_q;
  rfw_res_t           res_q;

  // request decode
  logic [11:0]        dsat;
  logic [15:0]        dq_full;
  logic signed [17:0] p_ext, x_lo, x_hi;
  logic signed [4:0]  lo_d, hi_d, w_d;
  logic [15:0]        dq_d;
  logic               box_d;

  function automatic logic signed [4:0] trunc_div(input logic signed [17:0] v);
    logic [17:0] mag;
    logic [5:0]  q;
    mag = v[17] ? 18'(-v) : v;
    q   = mag[17:12];
    return v[17] ? 5'(-q) : 5'(q);
  endfunction

  always_comb begin
    dsat    = (req_i.decimation > DEC_MAX) ? DEC_MAX : req_i.decimation;
    dq_full = {dsat, 4'b0};
    p_ext   = {{5{req_i.phase[12]}}, req_i.phase};
    x_lo    = p_ext - {2'b0, dq_full};
    x_hi    = p_ext + {2'b0, dq_full};
    w_d     = 5'(dsat[11:8]);
    box_d   = 1'b0;
    dq_d    = dq_full;
    lo_d    = '0;
    hi_d    = '0;
    if (kind_q == KIND_BOX) begin
      box_d = 1'b1;
      if (dsat > 12'd256) begin
        lo_d = -w_d;
        hi_d = w_d;
      end
    end else if (dsat <= 12'd256) begin
      // linear interpolation: the pair straddles the phase
      dq_d = 16'd4096;
      lo_d = req_i.phase[12] ? -5'sd1 : 5'sd0;
      hi_d = req_i.phase[12] ? 5'sd0 : 5'sd1;
    end else begin
      lo_d = trunc_div(x_lo);
      hi_d = trunc_div(x_hi);
    end
  end

  // raw weight of the current tap: tent weight in 2^-12 units, or 1 for the box filter
  logic signed [17:0] tap_pos, diff;
  logic [17:0]        tap_dist;
  logic [RAW_W-1:0]   raw;
  logic               last;

  always_comb begin
    tap_pos  = {idx_q[4], idx_q, 12'b0};
    diff     = tap_pos - {{5{p_q[12]}}, p_q};
    tap_dist = diff[17] ? 18'(-diff) : diff;
    if (box_q) begin
      raw = RAW_W'(1);
    end else if ({2'b0, dq_q} > tap_dist) begin
      raw = dq_q - tap_dist[15:0];
    end else begin
      raw = '0;
    end
    last = (idx_q == hi_q) || (cnt_q == 5'(MAX_TAPS - 1));
  end

  // normalization: (raw * 2^frac + sum/2) / sum
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  assign div_start = (state_q == ST_DIV);
  assign div_num   = NUM_W'({raw, WEIGHT_FRAC_BITS'(0)}) + NUM_W'(sum_q >> 1);

  rfw_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_TENT;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        kind_q <= filter_kind_e'(cfg_wdata_i);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            idx_q   <= lo_d;
            cnt_q   <= '0;
            state_q <= ST_SUM;
          end
        end
        // first pass: accumulate the raw weights
        ST_SUM: begin
          if (last) begin
            idx_q   <= lo_q;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            idx_q <= idx_q + 5'sd1;
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_DIV: begin
          state_q <= ST_WAIT;
        end
        // second pass: emit one normalized tap per division
        ST_WAIT: begin
          if (div_done) begin
            res_valid_q <= 1'b1;
            if (last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 5'sd1;
              cnt_q   <= cnt_q + 5'd1;
              state_q <= ST_DIV;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      p_q   <= req_i.phase;
      dq_q  <= dq_d;
      box_q <= box_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      sum_q <= '0;
    end else if (state_q == ST_SUM) begin
      sum_q <= sum_q + SUM_W'(raw);
    end
    if (state_q == ST_WAIT && div_done) begin
      res_q.tap_offset <= idx_q;
      res_q.weight     <= 16'(div_quo);
      res_q.last_tap   <= last;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i && !busy_o |=> busy_o)
    else $error("request not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_tap |-> !busy_o)
    else $error("still busy after last tap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_tap |-> busy_o)
    else $error("idle before last tap");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> state_q == ST_WAIT)
    else $error("divider result with no tap pending");

endmodule
